// File: hw/rtl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared constants, codes and controller/datapath interface types for the
// bitmap block allocator.
// ============================================================================
package bba_pkg;

    // Map geometry
    localparam int MAP_WORDS   = 64;
    localparam int WORD_BITS   = 64;
    localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);

    // Block index field
    localparam int INDEX_W     = 12;
    localparam int INDEX_SPAN  = 1 << INDEX_W;
    localparam int MAP_BLOCKS  = MAP_WORDS * WORD_BITS;
    localparam int BLOCK_LIMIT = (MAP_BLOCKS < INDEX_SPAN) ? MAP_BLOCKS : INDEX_SPAN;
    // Wide enough to hold the limit itself and any word/bit position
    localparam int LIMIT_W     = ((WORD_IDX_W + BIT_W) > INDEX_W) ?
                                 (WORD_IDX_W + BIT_W + 1) : (INDEX_W + 1);

    // Operation codes
    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_FREE   = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic load;         // capture request, rewind scan pointer
        logic advance;      // step the scan pointer
        logic claim;        // set the found bit, report its index
        logic release_blk;  // clear the requested bit, report ok
        logic report_full;  // report no free block
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_alloc;     // captured request is an allocate
        logic hit;          // fetched word holds a claimable free bit
        logic last_word;    // fetched word is the last word of the map
    } sts_t;

endpackage

// File: hw/rtl/bba_datapath.sv
// ============================================================================
// bba_datapath
// Bitmap storage, scan pointer, first-free search on one word and result
// registers.
// ============================================================================
module bba_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bba_pkg::cmd_t               cmd,
    output bba_pkg::sts_t               sts,
    input  logic                        s_func,
    input  logic [bba_pkg::INDEX_W-1:0] s_block_index,
    output logic [bba_pkg::INDEX_W-1:0] m_granted_index,
    output logic                        m_status
);

    // Bitmap memory; a word never written reads as all free
    logic [bba_pkg::WORD_BITS-1:0]  mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0]  valid_reg;

    logic                             func_reg;
    logic [bba_pkg::WORD_IDX_W-1:0]   req_word_reg;
    logic [bba_pkg::BIT_W-1:0]        req_bit_reg;
    logic                             req_in_range_reg;
    logic [bba_pkg::WORD_IDX_W-1:0]   ptr_reg;

    logic [bba_pkg::WORD_BITS-1:0]    rd_data_reg;
    logic                             rd_vld_reg;
    logic [bba_pkg::WORD_IDX_W-1:0]   rd_word_reg;

    logic [bba_pkg::INDEX_W-1:0]      granted_reg;
    logic                             status_reg;

    logic [bba_pkg::WORD_IDX_W-1:0]   rd_addr;
    logic [bba_pkg::WORD_BITS-1:0]    word;
    logic [bba_pkg::WORD_BITS-1:0]    free_bits;
    logic                             found;
    logic [bba_pkg::BIT_W-1:0]        found_bit;
    logic                             wr_en;
    logic [bba_pkg::WORD_BITS-1:0]    wr_data;
    logic                             in_range;

    assign rd_addr = (func_reg == bba_pkg::FUNC_ALLOC) ? ptr_reg : req_word_reg;
    assign word    = rd_vld_reg ? rd_data_reg : '0;

    assign in_range = {{(bba_pkg::LIMIT_W-bba_pkg::INDEX_W){1'b0}}, s_block_index}
                      < bba_pkg::LIMIT_W'(bba_pkg::BLOCK_LIMIT);

    // Free bits of the fetched word that lie below the block limit
    always_comb begin
        for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
            free_bits[b] = ~word[b] &&
                ({{(bba_pkg::LIMIT_W-bba_pkg::WORD_IDX_W-bba_pkg::BIT_W){1'b0}},
                  rd_word_reg, bba_pkg::BIT_W'(b)} < bba_pkg::LIMIT_W'(bba_pkg::BLOCK_LIMIT));
        end
    end

    // Lowest free bit
    always_comb begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found     = 1'b1;
                found_bit = bba_pkg::BIT_W'(b);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = word;
        if (cmd.claim) begin
            wr_en   = 1'b1;
            wr_data = word | (bba_pkg::WORD_BITS'(1) << found_bit);
        end else if (cmd.release_blk && req_in_range_reg) begin
            wr_en   = 1'b1;
            wr_data = word & ~(bba_pkg::WORD_BITS'(1) << req_bit_reg);
        end
    end

    assign sts.is_alloc  = (func_reg == bba_pkg::FUNC_ALLOC);
    assign sts.hit       = found;
    assign sts.last_word = (rd_word_reg == bba_pkg::WORD_IDX_W'(bba_pkg::MAP_WORDS - 1));

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[rd_word_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_word_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[rd_word_reg] <= 1'b1;
            end
            // Forward a same-cycle write to the valid flag of the read; the read data is not bypassed
            rd_vld_reg <= valid_reg[rd_addr] || (wr_en && (rd_addr == rd_word_reg));
        end
    end

    // Request capture, scan pointer and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_reg <= bba_pkg::FUNC_ALLOC;
            ptr_reg  <= '0;
        end else begin
            if (cmd.load) begin
                func_reg <= s_func;
                ptr_reg  <= '0;
            end else if (cmd.advance) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_word_reg     <= s_block_index[bba_pkg::BIT_W +: bba_pkg::WORD_IDX_W];
            req_bit_reg      <= s_block_index[bba_pkg::BIT_W-1:0];
            req_in_range_reg <= in_range;
        end
        if (cmd.claim) begin
            granted_reg <= bba_pkg::INDEX_W'({rd_word_reg, found_bit});
            status_reg  <= bba_pkg::STATUS_OK;
        end else if (cmd.report_full) begin
            granted_reg <= '0;
            status_reg  <= bba_pkg::STATUS_FULL;
        end else if (cmd.release_blk) begin
            granted_reg <= '0;
            status_reg  <= bba_pkg::STATUS_OK;
        end
    end

    assign m_granted_index = granted_reg;
    assign m_status        = status_reg;

endmodule

// File: hw/rtl/bba_ctrl.sv
// ============================================================================
// bba_ctrl
// Request sequencer: accepts a beat, runs the word scan or the bit clear,
// and holds the result beat until it is taken.
// ============================================================================
module bba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output bba_pkg::cmd_t  cmd,
    input  bba_pkg::sts_t  sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // First read is in flight; step past it for a scan
                cmd.advance = sts.is_alloc;
                state_next  = sts.is_alloc ? ST_SCAN : ST_CLEAR;
            end
            ST_SCAN: begin
                cmd.advance = 1'b1;
                if (sts.hit) begin
                    cmd.claim    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else if (sts.last_word) begin
                    cmd.report_full = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.release_blk = 1'b1;
                m_valid_next    = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hw/rtl/bitmap_block_allocator.sv
// ============================================================================
// bitmap_block_allocator
// First-fit block allocator over a bitmap of used blocks.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready): s_func selects the operation. Allocate
//   claims the lowest free block; free clears the bit of s_block_index
//   (indexes past the map are ignored). Every input beat yields exactly one
//   result beat on the output channel (m_valid/m_ready) carrying
//   m_granted_index and m_status (full when an allocate finds nothing).
//   Sequence: a free passes through the fetch and clear states before its result. An
//   allocate reads one 64-bit map word per cycle through the map memory's
//   single read port, from word 0 up to the first word with a free bit or
//   the last word of the map, and then returns its result. One request is
//   in flight at a time; the next beat is taken once the block is back in
//   idle and the result register is empty or being drained in the same
//   cycle.
//   Reset: aresetn (synchronous, active low) marks every block free at once
//   through per-word valid bits; no clearing pass is needed.
//   Stall: a result beat holds in the output register until m_ready; no new
//   request is accepted while it waits.
// ============================================================================
module bitmap_block_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [bba_pkg::INDEX_W-1:0] s_block_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bba_pkg::INDEX_W-1:0] m_granted_index,
    output logic                        m_status
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;

    // Sequencer: handshakes and command issue
    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Bitmap store, scan and result registers
    bba_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_func          (s_func),
        .s_block_index   (s_block_index),
        .m_granted_index (m_granted_index),
        .m_status        (m_status)
    );

endmodule

// File: tb/sv/bitmap_block_allocator_tb.sv
// ============================================================================
// bitmap_block_allocator_tb
// Self-checking bench for the first-fit bitmap block allocator. A driver
// and a monitor run as clocked processes: the driver feeds request beats
// from a pending queue, and the monitor predicts each grant at acceptance
// from a private copy of the used-block map. It then checks every result
// beat against the oldest prediction. The run starts with short directed
// cases and a random mix, then runs an allocate burst and closes with more
// long random allocate/free mixes, under three idling profiles in turn.
// ============================================================================
module bitmap_block_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 80;   // longest allocate latency plus margin
    localparam int BURST_ALLOCS = 100;

    typedef struct {
        logic                        func;
        logic [bba_pkg::INDEX_W-1:0] idx;
    } req_t;

    typedef struct packed {
        logic [bba_pkg::INDEX_W-1:0] granted;
        logic                        status;
    } grant_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_func = bba_pkg::FUNC_ALLOC;
    logic [bba_pkg::INDEX_W-1:0] s_block_index = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [bba_pkg::INDEX_W-1:0] m_granted_index;
    logic                        m_status;

    // Request beats waiting for the driver, and grants predicted but not yet seen
    req_t   pending_reqs[$];
    grant_t expected_grants[$];

    // Private copy of the used-block map
    logic [bba_pkg::WORD_BITS-1:0] used_words [bba_pkg::MAP_WORDS];
    int blocks_in_use = 0;
    int peak_in_use = 0;
    int hi_mark = 1;        // one past the highest block ever granted

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit in_taken = 1'b0;    // request beat accepted at the last rising edge

    int errors = 0;
    int results_seen = 0;
    int grants_ok = 0;
    int grants_full = 0;
    int frees_seen = 0;
    int cycle_count = 0;

    bitmap_block_allocator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_status        (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the map copy and return the grant it must produce.
    // Allocate claims the lowest clear bit below the block limit; free clears
    // the named bit and ignores indexes past the map.
    function automatic grant_t predict_grant(input logic func,
                                             input logic [bba_pkg::INDEX_W-1:0] idx);
        grant_t g;
        int     n;
        bit     found;
        g.granted = '0;
        g.status  = bba_pkg::STATUS_OK;
        found     = 1'b0;
        if (func == bba_pkg::FUNC_ALLOC) begin
            for (n = 0; n < bba_pkg::BLOCK_LIMIT && !found; n++) begin
                if (!used_words[n / bba_pkg::WORD_BITS][n % bba_pkg::WORD_BITS]) begin
                    used_words[n / bba_pkg::WORD_BITS][n % bba_pkg::WORD_BITS] = 1'b1;
                    g.granted = bba_pkg::INDEX_W'(n);
                    found = 1'b1;
                    blocks_in_use++;
                    if (blocks_in_use > peak_in_use) peak_in_use = blocks_in_use;
                    if (n + 1 > hi_mark) hi_mark = n + 1;
                end
            end
            if (!found) g.status = bba_pkg::STATUS_FULL;
        end else if (idx < bba_pkg::BLOCK_LIMIT) begin
            if (used_words[idx / bba_pkg::WORD_BITS][idx % bba_pkg::WORD_BITS])
                blocks_in_use--;
            used_words[idx / bba_pkg::WORD_BITS][idx % bba_pkg::WORD_BITS] = 1'b0;
        end
        return g;
    endfunction

    // Pick a block that is most likely in use, so frees mostly hit
    function automatic logic [bba_pkg::INDEX_W-1:0] pick_used_block();
        logic [bba_pkg::INDEX_W-1:0] cand;
        int                          t;
        cand = bba_pkg::INDEX_W'($urandom_range(0, hi_mark - 1));
        for (t = 0; t < 32; t++) begin
            if (used_words[cand / bba_pkg::WORD_BITS][cand % bba_pkg::WORD_BITS])
                return cand;
            cand = bba_pkg::INDEX_W'($urandom_range(0, hi_mark - 1));
        end
        return cand;
    endfunction

    task automatic push_req(input logic func, input logic [bba_pkg::INDEX_W-1:0] idx);
        pending_reqs.push_back('{func: func, idx: idx});
    endtask

    // Random allocate/free mix. Most frees target used blocks; the rest are
    // noise frees of any index (often already free).
    task automatic run_mix(input int count, input int alloc_pct);
        int i;
        for (i = 0; i < count; i++) begin
            while (pending_reqs.size() >= 4) @(negedge aclk);
            if ($urandom_range(0, 99) < alloc_pct)
                push_req(bba_pkg::FUNC_ALLOC, bba_pkg::INDEX_W'($urandom));
            else if ($urandom_range(0, 99) < 85)
                push_req(bba_pkg::FUNC_FREE, pick_used_block());
            else
                push_req(bba_pkg::FUNC_FREE, bba_pkg::INDEX_W'($urandom));
        end
    endtask

    // Driver: present a new beat only when the line is free or the last beat
    // was just taken; otherwise hold valid and payload.
    always @(negedge aclk) begin
        req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid       <= 1'b1;
                    s_func        <= nxt.func;
                    s_block_index <= nxt.idx;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: check the result beat first, so a grant leaving in the same
    // edge as a new request is matched against the older prediction.
    always @(posedge aclk) begin
        grant_t want;
        int     w;
        if (!aresetn) begin
            in_taken = 1'b0;
            for (w = 0; w < bba_pkg::MAP_WORDS; w++) used_words[w] = '0;
            blocks_in_use = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_grants.size() == 0) begin
                    $error("result beat with no grant pending: granted_index %0d status %0d",
                           m_granted_index, m_status);
                    errors++;
                end else begin
                    want = expected_grants.pop_front();
                    if (m_granted_index !== want.granted) begin
                        $error("granted_index mismatch: expected %0d, actual %0d",
                               want.granted, m_granted_index);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        errors++;
                    end
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                if (s_func == bba_pkg::FUNC_FREE) frees_seen++;
                want = predict_grant(s_func, s_block_index);
                if (s_func == bba_pkg::FUNC_ALLOC && want.status == bba_pkg::STATUS_FULL)
                    grants_full++;
                else if (s_func == bba_pkg::FUNC_ALLOC)
                    grants_ok++;
                expected_grants.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Profile one: sender idles lightly, receiver stalls often
        tx_idle_pct = 27;
        rx_idle_pct = 46;

        // Directed: first grants, reuse of a freed hole, double free, free of
        // the top index while free, word-boundary frees, index ignored on
        // allocate.
        push_req(bba_pkg::FUNC_ALLOC, 12'hFFF);
        push_req(bba_pkg::FUNC_ALLOC, 12'h000);
        push_req(bba_pkg::FUNC_ALLOC, 12'hAAA);
        push_req(bba_pkg::FUNC_FREE,  12'd1);
        push_req(bba_pkg::FUNC_ALLOC, 12'h555);
        push_req(bba_pkg::FUNC_FREE,  12'd4095);
        push_req(bba_pkg::FUNC_FREE,  12'd1);
        push_req(bba_pkg::FUNC_FREE,  12'd1);
        push_req(bba_pkg::FUNC_ALLOC, 12'h000);
        push_req(bba_pkg::FUNC_FREE,  12'd0);
        push_req(bba_pkg::FUNC_FREE,  12'd2048);
        push_req(bba_pkg::FUNC_FREE,  12'd63);
        push_req(bba_pkg::FUNC_FREE,  12'd64);
        push_req(bba_pkg::FUNC_ALLOC, 12'hFFF);
        push_req(bba_pkg::FUNC_ALLOC, 12'h800);

        run_mix(350, 65);

        // Profile two: the other way round. Drain, then an allocate burst
        // that pushes the scan across several map words.
        tx_idle_pct = 46;
        rx_idle_pct = 27;
        while (pending_reqs.size() != 0 || s_valid || expected_grants.size() != 0)
            @(negedge aclk);
        repeat (BURST_ALLOCS) push_req(bba_pkg::FUNC_ALLOC, bba_pkg::INDEX_W'($urandom));

        // Reopen the last and first blocks and the middle one
        push_req(bba_pkg::FUNC_FREE,  12'd4095);
        push_req(bba_pkg::FUNC_ALLOC, 12'h000);
        push_req(bba_pkg::FUNC_ALLOC, 12'hFFF);
        push_req(bba_pkg::FUNC_FREE,  12'd0);
        push_req(bba_pkg::FUNC_FREE,  12'd2048);
        push_req(bba_pkg::FUNC_ALLOC, 12'h123);
        push_req(bba_pkg::FUNC_ALLOC, 12'hEDC);
        push_req(bba_pkg::FUNC_ALLOC, 12'h000);

        // Churn with allocates slightly ahead of frees
        run_mix(300, 52);

        // Profile three: no idling. Thin the map out, then mix again.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_mix(200, 15);
        run_mix(200, 60);

        while (pending_reqs.size() != 0 || s_valid || expected_grants.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_grants.size() != 0) begin
            $error("%0d grants never returned", expected_grants.size());
            errors++;
        end

        $display("Checked %0d result beats: %0d grants, %0d full refusals, %0d frees.",
                 results_seen, grants_ok, grants_full, frees_seen);
        $display("Peak map occupancy %0d of %0d blocks; %0d mismatches.",
                 peak_in_use, bba_pkg::BLOCK_LIMIT, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
